[src/gdsd_pkg.sv]
// gdsd_pkg: shared constants, types and calendar helper functions
// for the date stepper; no dependencies
package gdsd_pkg;

  localparam logic [13:0] YEAR_LO   = 14'd1900;
  localparam logic [13:0] YEAR_HI   = 14'd10000;
  localparam logic [3:0]  MONTH_JAN = 4'd1;
  localparam logic [3:0]  MONTH_FEB = 4'd2;
  localparam logic [3:0]  MONTH_APR = 4'd4;
  localparam logic [3:0]  MONTH_JUN = 4'd6;
  localparam logic [3:0]  MONTH_SEP = 4'd9;
  localparam logic [3:0]  MONTH_NOV = 4'd11;
  localparam logic [3:0]  MONTH_DEC = 4'd12;
  localparam logic [4:0]  DAY_FIRST = 5'd1;
  localparam logic [4:0]  DAY_LAST_DEC = 5'd31;
  // 1 january 2000 fell on a saturday; 400 years later the pattern repeats
  localparam logic [2:0]  WD_JAN1_REF = 3'd6;
  localparam logic [8:0]  YEAR_DAYS = 9'd365;
  localparam logic [8:0]  LEAP_YEAR_DAYS = 9'd366;
  localparam logic [8:0]  CYCLE400_LAST = 9'd399;
  localparam logic [6:0]  CYCLE100_LAST = 7'd99;

  typedef struct packed {
    logic       done;
    logic [8:0] y400;
    logic [6:0] y100;
  } gdsd_mod_res_t;

  function automatic logic leap_of(input logic [1:0] y4, input logic [6:0] y100,
                                   input logic [8:0] y400);
    return ((y4 == 2'd0) && (y100 != 7'd0)) || (y400 == 9'd0);
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
      MONTH_FEB: len = leap ? 5'd29 : 5'd28;
      default:   len = 5'd31;
    endcase
    return len;
  endfunction

  function automatic logic [2:0] wd_add(input logic [2:0] a, input logic [2:0] b);
    logic [3:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s >= 4'd7) ? 3'(s - 4'd7) : s[2:0];
  endfunction

  // residue mod 7 of a value below 32
  function automatic logic [2:0] mod7_5(input logic [4:0] x);
    logic [4:0] r;
    r = x;
    if (r >= 5'd28) r = r - 5'd28;
    if (r >= 5'd14) r = r - 5'd14;
    if (r >= 5'd7)  r = r - 5'd7;
    return r[2:0];
  endfunction

endpackage

[src/gdsd_if.sv]
// gdsd_in_if / gdsd_out_if: valid-ready channels for the date stepper
// depends on nothing; offset width follows OFFSET_BITS
interface gdsd_in_if #(parameter int OFFSET_BITS = 16) ();
  logic                   valid;
  logic                   ready;
  logic                   action;
  logic [4:0]             start_day;
  logic [3:0]             start_month;
  logic [13:0]            start_year;
  logic [OFFSET_BITS-1:0] offset;

  modport source (output valid, action, start_day, start_month, start_year, offset,
                  input ready);
  modport sink (input valid, action, start_day, start_month, start_year, offset,
                output ready);
endinterface

interface gdsd_out_if ();
  logic        valid;
  logic        ready;
  logic [4:0]  end_day;
  logic [3:0]  end_month;
  logic [13:0] end_year;
  logic [8:0]  ordinal_in_year;
  logic [2:0]  weekday;
  logic        clamped;

  modport source (output valid, end_day, end_month, end_year, ordinal_in_year, weekday,
                  clamped, input ready);
  modport sink (input valid, end_day, end_month, end_year, ordinal_in_year, weekday,
                clamped, output ready);
endinterface

[src/gregorian_date_step_by_days.sv]
// gregorian_date_step_by_days: walks a gregorian date forward or back one day a cycle
// the time from the accepted beat to the result beat grows with offset, year mod 400
// and month; a clamped walk stops early at 1/1/1900 or 31/12/10000
// throughput: one item at a time, input ready again once the result is loaded;
// the day walk loop and the year-cycle weekday walk set how long an item takes
// reset: synchronous active-low rst_n clears the sequencer and output valid only
module gregorian_date_step_by_days import gdsd_pkg::*; #(
  parameter int OFFSET_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  gdsd_in_if.sink     in_if,
  gdsd_out_if.source  out_if
);

  // sequencer codes
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MOD   = 3'd1;
  localparam logic [2:0] S_FIX   = 3'd2;
  localparam logic [2:0] S_YWALK = 3'd3;
  localparam logic [2:0] S_MWALK = 3'd4;
  localparam logic [2:0] S_DADD  = 3'd5;
  localparam logic [2:0] S_STEP  = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0]             state_r, state_nxt;
  logic                   dir_r, dir_nxt;
  logic [4:0]             day_r, day_nxt;
  logic [3:0]             month_r, month_nxt;
  logic [13:0]            year_r, year_nxt;
  logic [OFFSET_BITS-1:0] left_r, left_nxt;
  logic [8:0]             y400_r, y400_nxt;
  logic [6:0]             y100_r, y100_nxt;
  logic [8:0]             k_r, k_nxt;
  logic [6:0]             k100_r, k100_nxt;
  logic [2:0]             wd_r, wd_nxt;
  logic [8:0]             ord_r, ord_nxt;
  logic [3:0]             mi_r, mi_nxt;
  logic                   clamp_r, clamp_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic [4:0]             o_day_r;
  logic [3:0]             o_month_r;
  logic [13:0]            o_year_r;
  logic [8:0]             o_ord_r;
  logic [2:0]             o_wd_r;
  logic                   o_clamp_r;

  logic                   accept;
  logic                   load_out;
  logic                   mod_start;
  gdsd_mod_res_t          mod_res;

  // calendar views of the working date
  logic                   leap_cur;
  logic                   leap_prev;
  logic                   leap_k;
  logic [4:0]             ml_cur;
  logic [4:0]             ml_prev_month;
  logic [4:0]             ml_walk;
  logic [8:0]             y400_dec;
  logic [6:0]             y100_dec;
  logic [13:0]            year_dec;
  logic                   at_hi;
  logic                   at_lo;
  logic [4:0]             day_fix;

  assign accept    = in_if.valid && in_if.ready;
  assign mod_start = accept;
  assign in_if.ready = (state_r == S_IDLE);
  assign load_out  = (state_r == S_DONE) && (!out_valid_r || out_if.ready);

  gdsd_mod_unit u_mod (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mod_start),
    .year_in (year_nxt),
    .res     (mod_res)
  );

  // previous-year counters, used when stepping back over new year
  assign y400_dec = (y400_r == 9'd0) ? CYCLE400_LAST : y400_r - 9'd1;
  assign y100_dec = (y100_r == 7'd0) ? CYCLE100_LAST : y100_r - 7'd1;
  assign year_dec = year_r - 14'd1;

  assign leap_cur  = leap_of(year_r[1:0], y100_r, y400_r);
  assign leap_prev = leap_of(year_dec[1:0], y100_dec, y400_dec);
  // year 2000+k inside one 400-year cycle
  assign leap_k    = ((k_r[1:0] == 2'd0) && (k100_r != 7'd0)) || (k_r == 9'd0);

  assign ml_cur        = month_len(month_r, leap_cur);
  assign ml_prev_month = month_len(month_r - 4'd1, leap_cur);
  assign ml_walk       = month_len(mi_r, leap_cur);

  assign at_hi = (year_r == YEAR_HI) && (month_r == MONTH_DEC) && (day_r == DAY_LAST_DEC);
  assign at_lo = (year_r == YEAR_LO) && (month_r == MONTH_JAN) && (day_r == DAY_FIRST);

  assign day_fix = (day_r > ml_cur) ? ml_cur : day_r;

  always_comb begin
    state_nxt = state_r;
    dir_nxt   = dir_r;
    day_nxt   = day_r;
    month_nxt = month_r;
    year_nxt  = year_r;
    left_nxt  = left_r;
    y400_nxt  = y400_r;
    y100_nxt  = y100_r;
    k_nxt     = k_r;
    k100_nxt  = k100_r;
    wd_nxt    = wd_r;
    ord_nxt   = ord_r;
    mi_nxt    = mi_r;
    clamp_nxt = clamp_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          // fold the start fields into range; day vs month length waits for the leap flag
          dir_nxt   = in_if.action;
          left_nxt  = in_if.offset;
          clamp_nxt = 1'b0;
          if (in_if.start_month < MONTH_JAN) begin
            month_nxt = MONTH_JAN;
          end else if (in_if.start_month > MONTH_DEC) begin
            month_nxt = MONTH_DEC;
          end else begin
            month_nxt = in_if.start_month;
          end
          if (in_if.start_year < YEAR_LO) begin
            year_nxt = YEAR_LO;
          end else if (in_if.start_year > YEAR_HI) begin
            year_nxt = YEAR_HI;
          end else begin
            year_nxt = in_if.start_year;
          end
          day_nxt   = (in_if.start_day < DAY_FIRST) ? DAY_FIRST : in_if.start_day;
          state_nxt = S_MOD;
        end
      end

      S_MOD: begin
        if (mod_res.done) begin
          y400_nxt  = mod_res.y400;
          y100_nxt  = mod_res.y100;
          state_nxt = S_FIX;
        end
      end

      S_FIX: begin
        day_nxt   = day_fix;
        k_nxt     = 9'd0;
        k100_nxt  = 7'd0;
        wd_nxt    = WD_JAN1_REF;
        state_nxt = S_YWALK;
      end

      S_YWALK: begin
        // weekday of 1 january: walk the 400-year cycle up to this year
        if (k_r == y400_r) begin
          ord_nxt   = 9'd0;
          mi_nxt    = MONTH_JAN;
          state_nxt = S_MWALK;
        end else begin
          wd_nxt   = wd_add(wd_r, leap_k ? 3'd2 : 3'd1);
          k_nxt    = k_r + 9'd1;
          k100_nxt = (k100_r == CYCLE100_LAST) ? 7'd0 : k100_r + 7'd1;
        end
      end

      S_MWALK: begin
        // add whole months before the start month
        if (mi_r == month_r) begin
          state_nxt = S_DADD;
        end else begin
          ord_nxt = ord_r + {4'd0, ml_walk};
          wd_nxt  = wd_add(wd_r, 3'(ml_walk - 5'd28));
          mi_nxt  = mi_r + 4'd1;
        end
      end

      S_DADD: begin
        ord_nxt   = ord_r + {4'd0, day_r};
        wd_nxt    = wd_add(wd_r, mod7_5(day_r - 5'd1));
        state_nxt = S_STEP;
      end

      S_STEP: begin
        if (left_r == '0) begin
          state_nxt = S_DONE;
        end else if (!dir_r) begin
          if (at_hi) begin
            clamp_nxt = 1'b1;
            state_nxt = S_DONE;
          end else begin
            left_nxt = left_r - OFFSET_BITS'(1);
            wd_nxt   = wd_add(wd_r, 3'd1);
            if (day_r < ml_cur) begin
              day_nxt = day_r + 5'd1;
              ord_nxt = ord_r + 9'd1;
            end else if (month_r < MONTH_DEC) begin
              month_nxt = month_r + 4'd1;
              day_nxt   = DAY_FIRST;
              ord_nxt   = ord_r + 9'd1;
            end else begin
              // new year's day
              year_nxt  = year_r + 14'd1;
              month_nxt = MONTH_JAN;
              day_nxt   = DAY_FIRST;
              ord_nxt   = 9'd1;
              y400_nxt  = (y400_r == CYCLE400_LAST) ? 9'd0 : y400_r + 9'd1;
              y100_nxt  = (y100_r == CYCLE100_LAST) ? 7'd0 : y100_r + 7'd1;
            end
          end
        end else begin
          if (at_lo) begin
            clamp_nxt = 1'b1;
            state_nxt = S_DONE;
          end else begin
            left_nxt = left_r - OFFSET_BITS'(1);
            wd_nxt   = wd_add(wd_r, 3'd6);
            if (day_r > DAY_FIRST) begin
              day_nxt = day_r - 5'd1;
              ord_nxt = ord_r - 9'd1;
            end else if (month_r > MONTH_JAN) begin
              // last day of the previous month, at its own length
              month_nxt = month_r - 4'd1;
              day_nxt   = ml_prev_month;
              ord_nxt   = ord_r - 9'd1;
            end else begin
              year_nxt  = year_dec;
              month_nxt = MONTH_DEC;
              day_nxt   = DAY_LAST_DEC;
              ord_nxt   = leap_prev ? LEAP_YEAR_DAYS : YEAR_DAYS;
              y400_nxt  = y400_dec;
              y100_nxt  = y100_dec;
            end
          end
        end
      end

      S_DONE: begin
        if (load_out) state_nxt = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // output register: result beat waits here while the next item may start
  always_comb begin
    out_valid_nxt = out_valid_r && !out_if.ready;
    if (load_out) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    dir_r   <= dir_nxt;
    day_r   <= day_nxt;
    month_r <= month_nxt;
    year_r  <= year_nxt;
    left_r  <= left_nxt;
    y400_r  <= y400_nxt;
    y100_r  <= y100_nxt;
    k_r     <= k_nxt;
    k100_r  <= k100_nxt;
    wd_r    <= wd_nxt;
    ord_r   <= ord_nxt;
    mi_r    <= mi_nxt;
    clamp_r <= clamp_nxt;
    if (load_out) begin
      o_day_r   <= day_r;
      o_month_r <= month_r;
      o_year_r  <= year_r;
      o_ord_r   <= ord_r;
      o_wd_r    <= wd_r;
      o_clamp_r <= clamp_r;
    end
  end

  assign out_if.valid           = out_valid_r;
  assign out_if.end_day         = o_day_r;
  assign out_if.end_month       = o_month_r;
  assign out_if.end_year        = o_year_r;
  assign out_if.ordinal_in_year = o_ord_r;
  assign out_if.weekday         = o_wd_r;
  assign out_if.clamped         = o_clamp_r;

`ifndef SYNTH
  a_accept_starts_mod: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == S_MOD)
    else $error("accepted beat did not start the sequencer");
  a_step_day_in_month: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_STEP |-> day_r >= DAY_FIRST && day_r <= ml_cur)
    else $error("day left its month while stepping");
  a_clamp_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && o_clamp_r |->
      (o_year_r == YEAR_LO && o_month_r == MONTH_JAN && o_day_r == DAY_FIRST) ||
      (o_year_r == YEAR_HI && o_month_r == MONTH_DEC && o_day_r == DAY_LAST_DEC))
    else $error("clamped result is not a range limit");
  a_result_ranges: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> o_wd_r < 3'd7 && o_ord_r >= 9'd1 && o_ord_r <= LEAP_YEAR_DAYS)
    else $error("weekday or ordinal out of range");
  a_step_counts_down: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_STEP && state_nxt == S_STEP |=> left_r == $past(left_r) - OFFSET_BITS'(1))
    else $error("day counter did not advance");
`endif

endmodule

[src/gdsd_mod_unit.sv]
// gdsd_mod_unit: restoring compare-subtract unit giving year mod 400 and mod 100
// depends on gdsd_pkg
module gdsd_mod_unit import gdsd_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [13:0]   year_in,
  output gdsd_mod_res_t res
);

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [2:0]  step_r, step_nxt;
  logic [13:0] rem_r, rem_nxt;
  logic [8:0]  y400_r, y400_nxt;
  logic [13:0] div;
  logic [13:0] rem_sub;

  // 400 and 100 scaled down step by step
  always_comb begin
    case (step_r)
      3'd0:    div = 14'd6400;
      3'd1:    div = 14'd3200;
      3'd2:    div = 14'd1600;
      3'd3:    div = 14'd800;
      3'd4:    div = 14'd400;
      3'd5:    div = 14'd200;
      default: div = 14'd100;
    endcase
  end

  assign rem_sub = (rem_r >= div) ? rem_r - div : rem_r;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    y400_nxt = y400_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = 3'd0;
      rem_nxt  = year_in;
    end else if (busy_r) begin
      rem_nxt  = rem_sub;
      step_nxt = step_r + 3'd1;
      if (step_r == 3'd4) y400_nxt = rem_sub[8:0];
      if (step_r == 3'd6) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= 3'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    rem_r  <= rem_nxt;
    y400_r <= y400_nxt;
  end

  assign res.done = done_r;
  assign res.y400 = y400_r;
  assign res.y100 = rem_r[6:0];

`ifndef SYNTH
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r && $past(busy_r))
    else $error("mod unit done without a run");
  a_rem_small_at_done: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (rem_r < 14'd100) && (y400_r < 9'd400))
    else $error("mod unit residue out of range");
  a_start_clears_step: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy_r && step_r == 3'd0)
    else $error("mod unit did not restart");
`endif

endmodule
